@@ hw/rtl/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Shared types and constants for the predictor front end and table engine.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int unsigned PC_W     = 32;
  localparam int unsigned CTR_W    = 3;
  localparam int unsigned CHO_W    = 2;
  localparam int unsigned LHIST_W  = 16;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CTR_W-1:0] CTR_MAX  = 3'd7;
  localparam logic [CTR_W-1:0] CTR_MID  = 3'd3;
  localparam logic [CTR_W-1:0] CTR_INIT = 3'd4;
  localparam logic [CHO_W-1:0] CHO_MAX  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MIN_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEDY_ENABLE   = 1'd1;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [PC_W-1:0] pc;
    logic            taken;
  } req_t;

  function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c,
                                                 input logic up,
                                                 input logic greedy);
    logic [CTR_W-1:0] r;
    r = c;
    if (up) begin
      if (greedy && c == CTR_MID) r = CTR_MAX;
      else if (c < CTR_MAX) r = c + 3'd1;
    end else begin
      if (greedy && c == CTR_INIT) r = '0;
      else if (c > 3'd0) r = c - 3'd1;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tbp_if.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor channels
// Valid/ready channel interfaces for request and prediction beats.
// ----------------------------------------------------------------------------
interface tbp_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] pc;
  logic        taken;
  modport source (output valid, cmd, pc, taken, input ready);
  modport sink (input valid, cmd, pc, taken, output ready);
endinterface

interface tbp_rsp_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  modport source (output valid, predicted_taken, input ready);
  modport sink (input valid, predicted_taken, output ready);
endinterface

@@ hw/rtl/tbp_front.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor front end
// Accepts request beats and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module tbp_front (
  input  logic          clk,
  input  logic          rst_n,
  tbp_req_if.sink       in_req,
  output logic          q_valid,
  output tbp_pkg::req_t q_data,
  input  logic          q_pop
);
  import tbp_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  req_t       beat;

  assign in_req.ready = (cnt_r != 2'd2);
  assign push    = in_req.valid && in_req.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rp_r];
  assign beat.cmd   = cmd_t'(in_req.cmd);
  assign beat.pc    = in_req.pc;
  assign beat.taken = in_req.taken;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

@@ hw/rtl/tbp_engine.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor table engine
// Reads the gshare, loop, local and chooser tables per request; trains them on updates.
// ----------------------------------------------------------------------------
module tbp_engine #(
  parameter int unsigned GLOBAL_INDEX_BITS  = 17,
  parameter int unsigned CHOOSER_INDEX_BITS = 16,
  parameter int unsigned LOCAL_TABLE_BITS   = 11,
  parameter int unsigned LOCAL_INDEX_BITS   = 17,
  parameter int unsigned LOOP_COUNT_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  tbp_pkg::req_t             q_data,
  output logic                      q_pop,
  input  logic [tbp_pkg::THR_W-1:0] loop_min_period,
  input  logic                      greedy_enable,
  tbp_rsp_if.source                 out_rsp
);
  import tbp_pkg::*;

  localparam int unsigned GW = GLOBAL_INDEX_BITS;
  localparam int unsigned CW = CHOOSER_INDEX_BITS;
  localparam int unsigned TW = LOCAL_TABLE_BITS;
  localparam int unsigned LW = LOCAL_INDEX_BITS;
  localparam int unsigned NW = LOOP_COUNT_BITS;
  localparam int unsigned GMAX = (GW > LW) ? GW : LW;
  localparam int unsigned CLR_W = ((GMAX > CW) ? GMAX : CW) + 1;
  localparam int unsigned TOP_W = ((NW > THR_W) ? NW : THR_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_WRITE, S_CREAD, S_CHOOSE, S_OUT
  } state_t;

  logic [CTR_W-1:0] gctr_mem [2**GW];
  logic [NW-1:0]    lcnt_mem [2**GW];
  logic [NW-1:0]    lper_mem [2**GW];
  logic [CHO_W-1:0] cho_mem  [2**CW];
  logic [LHIST_W-1:0] lhist_mem [2**TW];
  logic [CTR_W-1:0] lctr_mem [2**LW];

  state_t           state_r;
  logic [CLR_W-1:0] clr_r;
  logic [GW-1:0]    ghist_r;
  req_t             req_r;
  logic [GW-1:0]    gi_r;
  logic [LW-1:0]    li_r;
  logic [CTR_W-1:0] gctr_rd_r, lctr_rd_r;
  logic [NW-1:0]    lcnt_rd_r, lper_rd_r;
  logic [CHO_W-1:0] cho_rd_r;
  logic [LHIST_W-1:0] lhist_rd_r;
  logic [CTR_W-1:0] gctr_new_r;
  logic [NW-1:0]    lcnt_new_r, lper_new_r;
  logic             ok_out_r, pred_r;

  logic [TW-1:0]    ls;
  logic [CW-1:0]    ci;
  logic [GW-1:0]    gi;
  logic [GW-1:0]    gi_c;
  logic [LW-1:0]    li;
  logic             g_op, l_op, g_ok, l_ok;
  logic [CTR_W-1:0] gctr_nxt;
  logic [NW-1:0]    lcnt_nxt, lper_nxt;
  logic [LHIST_W-1:0] lhist_nxt;
  logic [GW-1:0]    gi_clr;
  logic [LW-1:0]    li_clr;
  logic [CW-1:0]    ci_clr;
  logic [TW-1:0]    ls_clr;

  assign ls = q_data.pc[PC_W-1 -: TW];
  assign ci = req_r.pc[PC_W-1 -: CW];
  assign gi = q_data.pc[GW-1:0] ^ ghist_r;
  assign gi_c = req_r.pc[GW-1:0] ^ ghist_r;
  assign gi_clr = clr_r[GW-1:0];
  assign li_clr = clr_r[LW-1:0];
  assign ci_clr = clr_r[CW-1:0];
  assign ls_clr = clr_r[TW-1:0];

  if (LW <= LHIST_W) begin : g_li_narrow
    assign li = req_r.pc[LW-1:0] ^ lhist_rd_r[LW-1:0];
  end else begin : g_li_wide
    assign li = req_r.pc[LW-1:0] ^ {{(LW-LHIST_W){1'b0}}, lhist_rd_r};
  end

  // Opinion of each component from registered reads.
  assign g_op = ({{(TOP_W-NW){1'b0}}, lper_rd_r} >=
                 {{(TOP_W-THR_W){1'b0}}, loop_min_period})
                ? (lcnt_rd_r == lper_rd_r) : (gctr_rd_r > CTR_MID);
  assign l_op = (lctr_rd_r > CTR_MID);
  assign g_ok = (g_op == req_r.taken);
  assign l_ok = (l_op == req_r.taken);

  always_comb begin
    gctr_nxt = ctr_train(gctr_rd_r, req_r.taken, greedy_enable);
    lcnt_nxt = lcnt_rd_r;
    lper_nxt = lper_rd_r;
    if (req_r.taken) begin
      if (lper_rd_r != '0 && lper_rd_r == lcnt_rd_r) lper_nxt = '0;
      else if (lcnt_rd_r != {NW{1'b1}}) lcnt_nxt = lcnt_rd_r + NW'(1);
    end else begin
      lper_nxt = lcnt_rd_r;
      lcnt_nxt = '0;
    end
    lhist_nxt = {lhist_rd_r[LHIST_W-2:0], req_r.taken};
  end

  assign q_pop = (state_r == S_IDLE) && q_valid && !out_rsp.valid;

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      if (clr_r < CLR_W'(2**GW)) begin
        gctr_mem[gi_clr] <= CTR_INIT;
        lcnt_mem[gi_clr] <= '0;
        lper_mem[gi_clr] <= '0;
      end
      if (clr_r < CLR_W'(2**LW)) lctr_mem[li_clr] <= CTR_INIT;
      if (clr_r < CLR_W'(2**CW)) cho_mem[ci_clr] <= '0;
      if (clr_r < CLR_W'(2**TW)) lhist_mem[ls_clr] <= '0;
    end else if (state_r == S_WRITE) begin
      gctr_mem[gi_r] <= gctr_new_r;
      lcnt_mem[gi_r] <= lcnt_new_r;
      lper_mem[gi_r] <= lper_new_r;
      lctr_mem[li_r] <= ctr_train(lctr_rd_r, req_r.taken, greedy_enable);
      lhist_mem[req_r.pc[PC_W-1 -: TW]] <= lhist_nxt;
    end else if (state_r == S_CHOOSE && req_r.cmd == CMD_UPDATE) begin
      if (l_ok && !g_ok && cho_rd_r != CHO_MAX) cho_mem[ci] <= cho_rd_r + 2'd1;
      else if (g_ok && !l_ok && cho_rd_r != 2'd0) cho_mem[ci] <= cho_rd_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      gctr_rd_r  <= gctr_mem[gi];
      lcnt_rd_r  <= lcnt_mem[gi];
      lper_rd_r  <= lper_mem[gi];
      lhist_rd_r <= lhist_mem[ls];
      req_r      <= q_data;
      gi_r       <= gi;
    end
    if (state_r == S_READ) begin
      lctr_rd_r  <= lctr_mem[li];
      cho_rd_r   <= cho_mem[ci];
      li_r       <= li;
      gctr_new_r <= gctr_nxt;
      lcnt_new_r <= lcnt_nxt;
      lper_new_r <= lper_nxt;
    end
    if (state_r == S_CREAD) begin
      gctr_rd_r <= gctr_mem[gi_c];
      lcnt_rd_r <= lcnt_mem[gi_c];
      lper_rd_r <= lper_mem[gi_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      ghist_r  <= '0;
      ok_out_r <= 1'b0;
      pred_r   <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) ok_out_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLR_W'(1);
          if (clr_r == {1'b0, {(CLR_W-1){1'b1}}}) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) state_r <= S_READ;
        end
        S_READ: begin
          if (req_r.cmd == CMD_PREDICT) state_r <= S_CHOOSE;
          else state_r <= S_WRITE;
        end
        S_WRITE: begin
          ghist_r <= {ghist_r[GW-2:0], req_r.taken};
          state_r <= S_CREAD;
        end
        S_CREAD: state_r <= S_CHOOSE;
        S_CHOOSE: begin
          if (req_r.cmd == CMD_PREDICT) begin
            pred_r   <= (cho_rd_r < 2'd2) ? g_op : l_op;
            ok_out_r <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_rsp.valid = ok_out_r;
  assign out_rsp.predicted_taken = pred_r;
endmodule

@@ hw/rtl/tournament_branch_predictor.sv @@
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Chooser-selected gshare/loop and local-history direction predictor.
// ----------------------------------------------------------------------------
// A predict beat is read from the tables and resolved by the chooser; an update
// also writes back and re-reads the single-port global tables before the chooser
// step. No new beat is taken until the last is done and any prediction is taken.
// After reset a clearing pass initializes all tables before the first beat is
// processed.
module tournament_branch_predictor #(
  parameter int unsigned GLOBAL_INDEX_BITS  = 17,
  parameter int unsigned CHOOSER_INDEX_BITS = 16,
  parameter int unsigned LOCAL_TABLE_BITS   = 11,
  parameter int unsigned LOCAL_INDEX_BITS   = 17,
  parameter int unsigned LOOP_COUNT_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tbp_req_if.sink                             in_req,
  tbp_rsp_if.source                           out_rsp,
  input  logic                                cfg_we,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tbp_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic             greedy_r;
  logic             q_valid, q_pop;
  req_t             q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_W'(7);
      greedy_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOOP_MIN_PERIOD: thr_r    <= cfg_data[THR_W-1:0];
        CFG_GREEDY_ENABLE:   greedy_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  tbp_engine #(
    .GLOBAL_INDEX_BITS  (GLOBAL_INDEX_BITS),
    .CHOOSER_INDEX_BITS (CHOOSER_INDEX_BITS),
    .LOCAL_TABLE_BITS   (LOCAL_TABLE_BITS),
    .LOCAL_INDEX_BITS   (LOCAL_INDEX_BITS),
    .LOOP_COUNT_BITS    (LOOP_COUNT_BITS)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .loop_min_period (thr_r),
    .greedy_enable   (greedy_r),
    .out_rsp         (out_rsp)
  );
endmodule
